// ----- hw/rtl/assert_macros.svh -----
// shared assertion macros, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication property sampled at every rising clock edge
`define QDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a condition that must never hold
`define QDM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/qdm_pkg.sv -----
`timescale 1ns / 1ps

package qdm_pkg;

	// item kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_INIT   = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	// decoded step of one transition
	typedef logic [1:0] step_t;
	localparam step_t STEP_ZERO = 2'd0;
	localparam step_t STEP_INC  = 2'd1;
	localparam step_t STEP_DEC  = 2'd2;

	// x4 transition table, indexed by {old phase, new phase}, phase = {A, B}
	localparam step_t STEP_TABLE [16] = '{
		STEP_ZERO, STEP_DEC,  STEP_INC,  STEP_ZERO,
		STEP_INC,  STEP_ZERO, STEP_ZERO, STEP_DEC,
		STEP_DEC,  STEP_ZERO, STEP_ZERO, STEP_INC,
		STEP_ZERO, STEP_INC,  STEP_DEC,  STEP_ZERO
	};

	// result queue depth and its pointer width
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PW    = 2;

	// one result item
	typedef struct packed {
		logic [1:0]         channel_out;
		logic signed [31:0] delta_count;
		logic [31:0]        invalid_count;
	} out_item_t;

endpackage

// ----- hw/rtl/qdm_ram.sv -----
`timescale 1ns / 1ps

module qdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/qdm_out_fifo.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qdm_out_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  qdm_pkg::out_item_t       push_data,
	input  logic                     pop_ready,
	output logic                     out_valid,
	output qdm_pkg::out_item_t       out_data,
	output logic [qdm_pkg::OUT_PW-1:0] count
);

	localparam logic [qdm_pkg::OUT_PW-1:0] LAST_PTR = qdm_pkg::OUT_PW'(qdm_pkg::OUT_DEPTH - 1);
	localparam logic [qdm_pkg::OUT_PW-1:0] FULL_CNT = qdm_pkg::OUT_PW'(qdm_pkg::OUT_DEPTH);

	qdm_pkg::out_item_t               mem_q [qdm_pkg::OUT_DEPTH];
	logic [qdm_pkg::OUT_PW-1:0]       wr_ptr_q;
	logic [qdm_pkg::OUT_PW-1:0]       rd_ptr_q;
	logic [qdm_pkg::OUT_PW-1:0]       count_q;
	logic                             pop;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && pop_ready;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`QDM_ASSERT(a_no_overflow, push |-> ((count_q != FULL_CNT) || pop), "result queue overflow")
	`QDM_NEVER(a_level_range, count_q > FULL_CNT, "result queue level out of range")

endmodule

// ----- hw/rtl/quadrature_decoder_multi.sv -----
`timescale 1ns / 1ps
// channel  | direction | tvalid/tready | tuser      | tdata (low bit up)
// s_axis   | in        | yes           | kind [1:0] | channel[1:0], a_level, b_level, pad
// m_axis   | out       | yes           | -          | channel_out[1:0], delta_count[31:0],
//          |           |               |            | invalid_count[31:0], pad
// One item per cycle while s_axis_tready is high; an item reads its channel entry from
// the state RAM on acceptance and writes it back in the next cycle, with the written
// entry forwarded. A read result reaches m_axis via the registered RAM read and the queue.
// Reset clears per-channel valid bits at once, so no clearing pass runs after reset.
// A three-entry result queue absorbs output stalls; s_axis stalls only when it would fill.
`include "assert_macros.svh"

module quadrature_decoder_multi #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // channel[1:0], a_level[2], b_level[3], zero[7:4]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // channel_out[1:0], delta_count[33:2],
	                                   // invalid_count[65:34], zero[71:66]
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int EW = 2 + 2 * COUNT_WIDTH;

	logic [1:0]          kind_in;
	logic [1:0]          ch_in;
	logic [1:0]          cur_in;
	logic [4:0]          ch_ext;
	logic                ch_ok;
	logic [AW-1:0]       rd_idx;
	logic                accept;
	logic                live;
	logic                fwd_hit;

	logic                vld_s1;
	logic [1:0]          kind_s1;
	logic [1:0]          ch_s1;
	logic [1:0]          cur_s1;
	logic [AW-1:0]       idx_s1;
	logic                fwd_s1;
	logic                rdvld_s1;
	logic [EW-1:0]       wb_q;
	logic [NUM_CHANNELS-1:0] valid_q;

	logic [EW-1:0]       ram_rdata;
	logic [EW-1:0]       old_entry;
	logic [1:0]          old_phase;
	logic [COUNT_WIDTH-1:0] old_step;
	logic [COUNT_WIDTH-1:0] old_bad;
	logic [1:0]          new_phase;
	logic [COUNT_WIDTH-1:0] new_step;
	logic [COUNT_WIDTH-1:0] new_bad;
	logic [EW-1:0]       wr_data;
	qdm_pkg::step_t      step_code;
	logic [63:0]         step_wide;
	logic [63:0]         bad_wide;

	logic                push;
	qdm_pkg::out_item_t  push_data;
	qdm_pkg::out_item_t  head;
	logic [qdm_pkg::OUT_PW-1:0] fifo_count;

	// input field decode
	assign kind_in = s_axis_tuser;
	assign ch_in   = s_axis_tdata[1:0];
	assign cur_in  = {s_axis_tdata[2], s_axis_tdata[3]};
	assign ch_ext  = {3'b000, ch_in};
	assign ch_ok   = (ch_ext < 5'(NUM_CHANNELS));
	assign rd_idx  = ch_ext[AW-1:0];
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign live    = accept && ch_ok && (kind_in != qdm_pkg::KIND_RSVD);

	// the write in flight this cycle hits the entry being read
	assign fwd_hit = vld_s1 && (idx_s1 == rd_idx);

	// room for this item plus any read still in the pipe
	assign s_axis_tready = ((3'(fifo_count) + 3'(push)) <= 3'(qdm_pkg::OUT_DEPTH - 1));

	qdm_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_CHANNELS)
	) u_state_ram (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(idx_s1),
		.wdata(wr_data),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			vld_s1 <= live;
			if (vld_s1) begin
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// stage 1 payload and forwarded write data
	always_ff @(posedge clk) begin
		kind_s1  <= kind_in;
		ch_s1    <= ch_in;
		cur_s1   <= cur_in;
		idx_s1   <= rd_idx;
		fwd_s1   <= fwd_hit;
		rdvld_s1 <= ch_ok && valid_q[rd_idx];
		wb_q     <= wr_data;
	end

	// select the current entry: forwarded, stored, or reset value
	always_comb begin
		if (fwd_s1) begin
			old_entry = wb_q;
		end else if (rdvld_s1) begin
			old_entry = ram_rdata;
		end else begin
			old_entry = '0;
		end
	end

	assign old_phase = old_entry[1:0];
	assign old_step  = old_entry[COUNT_WIDTH+1:2];
	assign old_bad   = old_entry[EW-1:COUNT_WIDTH+2];
	assign step_code = qdm_pkg::STEP_TABLE[{old_phase, cur_s1}];

	// read-modify-write of the channel entry
	always_comb begin
		new_phase = old_phase;
		new_step  = old_step;
		new_bad   = old_bad;
		unique case (kind_s1)
			qdm_pkg::KIND_SAMPLE: begin
				new_phase = cur_s1;
				priority if ((cur_s1 != old_phase) && (step_code == qdm_pkg::STEP_ZERO)) begin
					new_bad = old_bad + COUNT_WIDTH'(1);
				end else if (step_code == qdm_pkg::STEP_INC) begin
					new_step = old_step + COUNT_WIDTH'(1);
				end else if (step_code == qdm_pkg::STEP_DEC) begin
					new_step = old_step - COUNT_WIDTH'(1);
				end else begin
					new_step = old_step;
				end
			end
			qdm_pkg::KIND_READ: begin
				new_step = '0;
				new_bad  = '0;
			end
			qdm_pkg::KIND_INIT: begin
				new_phase = cur_s1;
				new_step  = '0;
				new_bad   = '0;
			end
			default: begin
				new_phase = old_phase;
			end
		endcase
	end

	assign wr_data = {new_bad, new_step, new_phase};

	// result of a read item, counters cut to 32 bits
	assign step_wide               = 64'(old_step);
	assign bad_wide                = 64'(old_bad);
	assign push                    = vld_s1 && (kind_s1 == qdm_pkg::KIND_READ);
	assign push_data.channel_out   = ch_s1;
	assign push_data.delta_count   = step_wide[31:0];
	assign push_data.invalid_count = bad_wide[31:0];

	qdm_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_data (head),
		.count    (fifo_count)
	);

	assign m_axis_tdata = {6'b000000, head.invalid_count, head.delta_count, head.channel_out};

	`QDM_ASSERT(a_read_enters_s1, (accept && ch_ok && (kind_in == qdm_pkg::KIND_READ)) |=> push, "accepted read item did not reach stage 1")
	`QDM_ASSERT(a_entry_marked, vld_s1 |=> valid_q[$past(idx_s1)], "written channel entry not marked valid")
	`QDM_ASSERT(a_fwd_after_write, (vld_s1 && fwd_s1) |-> $past(vld_s1), "forwarding without a write in the previous cycle")

endmodule

// ----- tb/qdm_count_checker.sv -----
`timescale 1ns / 1ps

module qdm_count_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // channel[1:0], a_level[2], b_level[3], zero[7:4]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,  // channel_out[1:0], delta_count[33:2],
	                                   // invalid_count[65:34], zero[71:66]
	output int          fails,
	output int          pending
);
	import qdm_pkg::*;

	localparam int CH_COUNT = 4;

	// x4 step per {old phase, new phase}, phase = {A, B}
	localparam int STEP_LUT [16] = '{
		0, -1,  1,  0,
		1,  0,  0, -1,
		-1, 0,  0,  1,
		0,  1, -1,  0
	};

	logic [1:0]  phase_r [CH_COUNT];
	logic [31:0] delta_r [CH_COUNT];
	logic [31:0] bad_r   [CH_COUNT];
	out_item_t   expected_reads [$];

	// update the channel counters for one accepted item
	task automatic track_item(input logic [1:0] kind, input logic [1:0] ch,
			input logic [1:0] ph);
		int        step;
		out_item_t rd;
		step = STEP_LUT[{phase_r[ch], ph}];
		case (kind)
			KIND_SAMPLE: begin
				if (ph != phase_r[ch] && step == 0)
					bad_r[ch] = bad_r[ch] + 32'd1;
				else
					delta_r[ch] = delta_r[ch] + 32'(step);
				phase_r[ch] = ph;
			end
			KIND_READ: begin
				rd.channel_out   = ch;
				rd.delta_count   = delta_r[ch];
				rd.invalid_count = bad_r[ch];
				expected_reads.push_back(rd);
				delta_r[ch] = '0;
				bad_r[ch]   = '0;
			end
			KIND_INIT: begin
				phase_r[ch] = ph;
				delta_r[ch] = '0;
				bad_r[ch]   = '0;
			end
			default: begin
			end
		endcase
	endtask

	// compare one result item with the oldest expected read
	task automatic check_result(input logic [71:0] data);
		out_item_t want;
		if (expected_reads.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual channel %0d delta %0d invalid %0d",
				$time, data[1:0], $signed(data[33:2]), data[65:34]);
			fails++;
		end else begin
			want = expected_reads.pop_front();
			if (data[1:0] !== want.channel_out) begin
				$display("%0t: channel_out mismatch, expected %0d actual %0d",
					$time, want.channel_out, data[1:0]);
				fails++;
			end
			if (data[33:2] !== want.delta_count) begin
				$display("%0t: delta_count mismatch on channel %0d, expected %0d actual %0d",
					$time, want.channel_out, want.delta_count, $signed(data[33:2]));
				fails++;
			end
			if (data[65:34] !== want.invalid_count) begin
				$display("%0t: invalid_count mismatch on channel %0d, expected %0d actual %0d",
					$time, want.channel_out, want.invalid_count, data[65:34]);
				fails++;
			end
		end
	endtask

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH_COUNT; i++) begin
				phase_r[i] = '0;
				delta_r[i] = '0;
				bad_r[i]   = '0;
			end
			expected_reads.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				track_item(s_axis_tuser, s_axis_tdata[1:0],
					{s_axis_tdata[2], s_axis_tdata[3]});
			pending = expected_reads.size();
		end
	end

endmodule

// ----- tb/tb_quadrature_decoder_multi.sv -----
`timescale 1ns / 1ps

module tb_quadrature_decoder_multi;
	import qdm_pkg::*;

	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_TAIL   = 50;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	int          fail_count;
	int          pending_reads;
	logic [1:0]  enc_phase [4];
	int          sent_items;
	bit          quiet;
	int          ch_pick;
	int          op_pick;
	int          run_len;
	bit          dir_up;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	quadrature_decoder_multi dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	qdm_count_checker u_count_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fails         (fail_count),
		.pending       (pending_reads)
	);

	// one gray-code step forward or backward, phase = {A, B}
	function automatic logic [1:0] next_phase(input logic [1:0] p, input bit up);
		case (p)
			2'd0: next_phase = up ? 2'd2 : 2'd1;
			2'd2: next_phase = up ? 2'd3 : 2'd0;
			2'd3: next_phase = up ? 2'd1 : 2'd2;
			default: next_phase = up ? 2'd0 : 2'd3;
		endcase
	endfunction

	// drive one item at the falling edge, with an occasional idle burst before it
	task automatic send_item(input logic [1:0] kind, input logic [1:0] ch,
			input logic [1:0] ph);
		int gap;
		gap = (!quiet && $urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'd0, ph[0], ph[1], ch};
		do @(posedge clk); while (!s_axis_tready);
		if (kind == KIND_SAMPLE || kind == KIND_INIT)
			enc_phase[ch] = ph;
		if (kind != KIND_RSVD)
			sent_items++;
	endtask

	// result side backpressure in random bursts
	initial begin
		int hold;
		bit stall;
		hold  = 0;
		stall = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (hold == 0) begin
					stall = ($urandom_range(0, 3) == 0);
					hold  = stall ? $urandom_range(1, 19) : $urandom_range(1, 30);
				end
				m_axis_tready <= !stall;
				hold--;
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = KIND_SAMPLE;
		quiet         = 1'b0;
		sent_items    = 0;
		for (int i = 0; i < 4; i++)
			enc_phase[i] = 2'd0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// full forward cycle, unchanged phase and a double flip on channel 0
		send_item(KIND_INIT, 2'd0, 2'd0);
		send_item(KIND_SAMPLE, 2'd0, 2'd2);
		send_item(KIND_SAMPLE, 2'd0, 2'd3);
		send_item(KIND_SAMPLE, 2'd0, 2'd1);
		send_item(KIND_SAMPLE, 2'd0, 2'd0);
		send_item(KIND_SAMPLE, 2'd0, 2'd0);
		send_item(KIND_SAMPLE, 2'd0, 2'd3);
		send_item(KIND_READ, 2'd0, 2'd3);
		// backward steps below zero on channel 1
		send_item(KIND_INIT, 2'd1, 2'd3);
		send_item(KIND_SAMPLE, 2'd1, 2'd2);
		send_item(KIND_SAMPLE, 2'd1, 2'd0);
		send_item(KIND_READ, 2'd1, 2'd0);
		// reserved kind leaves channel 2 alone
		send_item(KIND_RSVD, 2'd2, 2'd3);
		send_item(KIND_SAMPLE, 2'd2, 2'd2);
		send_item(KIND_SAMPLE, 2'd3, 2'd1);
		send_item(KIND_SAMPLE, 2'd3, 2'd2);
		send_item(KIND_READ, 2'd2, 2'd1);
		send_item(KIND_READ, 2'd3, 2'd2);
		// reads of already cleared counters
		send_item(KIND_READ, 2'd0, 2'd0);
		send_item(KIND_READ, 2'd3, 2'd3);
		// initialize clears counters after activity
		send_item(KIND_SAMPLE, 2'd2, 2'd3);
		send_item(KIND_INIT, 2'd2, 2'd1);
		send_item(KIND_READ, 2'd2, 2'd0);

		// random part: mostly clean step runs, some noise
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			quiet   = (sent_items >= RANDOM_ITEMS - QUIET_TAIL);
			ch_pick = $urandom_range(0, 3);
			op_pick = $urandom_range(0, 99);
			if (op_pick < 60) begin
				run_len = $urandom_range(1, 8);
				dir_up  = $urandom_range(0, 1);
				repeat (run_len)
					send_item(KIND_SAMPLE, 2'(ch_pick), next_phase(enc_phase[ch_pick], dir_up));
			end else if (op_pick < 70) begin
				send_item(KIND_SAMPLE, 2'(ch_pick), 2'($urandom_range(0, 3)));
			end else if (op_pick < 85) begin
				send_item(KIND_READ, 2'(ch_pick), 2'($urandom_range(0, 3)));
			end else if (op_pick < 92) begin
				send_item(KIND_INIT, 2'(ch_pick), 2'($urandom_range(0, 3)));
			end else if (op_pick < 96) begin
				send_item(KIND_SAMPLE, 2'(ch_pick), enc_phase[ch_pick] ^ 2'd3);
			end else begin
				send_item(KIND_RSVD, 2'(ch_pick), 2'($urandom_range(0, 3)));
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// drain outstanding reads
		while (pending_reads != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
